[rtl/core/bw2d_pkg.sv]
// Shared types and constants of the 2D barycentric weight pipeline.
`timescale 1ns / 1ps
`default_nettype none
package bw2d_pkg;

  // Width of one weight word on the result side.
  localparam int WEIGHT_BITS = 32;

  // Front stages: differences, products, numerators, magnitudes, setup.
  localparam int FRONT_STAGES = 5;

  // Cycles from an accepted start to the done strobe.
  localparam int PIPE_LATENCY = FRONT_STAGES + WEIGHT_BITS + 1;

  typedef logic signed [WEIGHT_BITS-1:0] weight_t;

endpackage
`default_nettype wire

[rtl/core/barycentric_weights_2d.sv]
// Pipelined barycentric weights of a 2D point in a triangle.
//
// Usage: drive the point and the three vertices and raise start for one
// cycle per word. A word is taken at each rising edge with start high and
// busy low. Busy is low except during reset, so a new word can be taken
// in every cycle.
// Each result word appears on weight_one, weight_two, weight_three and
// degenerate for exactly one cycle, marked by done. The receiver cannot
// stall, and the pipeline never holds anything back: throughput is one
// word per cycle.
// The pipeline has five front stages (differences, products, numerators,
// magnitudes, setup), one restoring divider stage per quotient bit for 32
// bits, and one output stage.
// Weights are signed Q15.16 values of -N/D, truncated toward zero and
// saturated. A zero-area triangle gives zero weights and degenerate high.
// Synchronous reset empties the pipeline: words in flight are dropped and
// done stays low until new words arrive.
`timescale 1ns / 1ps
`default_nettype none
module barycentric_weights_2d
  import bw2d_pkg::*;
#(
  parameter int COORD_BITS       = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  input  wire signed [COORD_BITS-1:0] point_x,
  input  wire signed [COORD_BITS-1:0] point_y,
  input  wire signed [COORD_BITS-1:0] vertex1_x,
  input  wire signed [COORD_BITS-1:0] vertex1_y,
  input  wire signed [COORD_BITS-1:0] vertex2_x,
  input  wire signed [COORD_BITS-1:0] vertex2_y,
  input  wire signed [COORD_BITS-1:0] vertex3_x,
  input  wire signed [COORD_BITS-1:0] vertex3_y,
  output logic                        done,
  output weight_t                     weight_one,
  output weight_t                     weight_two,
  output weight_t                     weight_three,
  output logic                        degenerate
);

  localparam int CW = COORD_BITS + 1;
  localparam int PW = 2 * CW;
  localparam int NW = PW + 1;
  localparam int QB = WEIGHT_BITS;
  localparam int WW = NW + QB;

  logic accept;

  assign busy   = rst;
  assign accept = start && !busy;

  // Stage A: coordinate differences.
  logic                 va;
  logic signed [CW-1:0] da [3];
  logic signed [CW-1:0] db [3];
  logic signed [CW-1:0] dc [3];
  logic signed [CW-1:0] de [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= accept;
    end
    da[0] <= CW'(vertex3_x) - CW'(vertex2_x);
    db[0] <= CW'(point_y)   - CW'(vertex2_y);
    dc[0] <= CW'(point_x)   - CW'(vertex2_x);
    de[0] <= CW'(vertex3_y) - CW'(vertex2_y);
    da[1] <= CW'(vertex1_x) - CW'(vertex3_x);
    db[1] <= CW'(point_y)   - CW'(vertex3_y);
    dc[1] <= CW'(point_x)   - CW'(vertex3_x);
    de[1] <= CW'(vertex1_y) - CW'(vertex3_y);
    da[2] <= CW'(vertex2_x) - CW'(vertex1_x);
    db[2] <= CW'(point_y)   - CW'(vertex1_y);
    dc[2] <= CW'(point_x)   - CW'(vertex1_x);
    de[2] <= CW'(vertex2_y) - CW'(vertex1_y);
  end

  // Stage B: the eight cross products.
  logic                 vb;
  logic signed [PW-1:0] pab [3];
  logic signed [PW-1:0] pce [3];
  logic signed [PW-1:0] pd0;
  logic signed [PW-1:0] pd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    for (int i = 0; i < 3; i++) begin
      pab[i] <= da[i] * db[i];
      pce[i] <= dc[i] * de[i];
    end
    pd0 <= da[2] * de[1];
    pd1 <= da[1] * de[2];
  end

  // Stage C: numerators and doubled area.
  logic                 vc;
  logic signed [NW-1:0] num [3];
  logic signed [NW-1:0] den;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
    for (int i = 0; i < 3; i++) begin
      num[i] <= NW'(pab[i]) - NW'(pce[i]);
    end
    den <= NW'(pd0) - NW'(pd1);
  end

  // Stage D: magnitudes, result signs and the zero-area flag.
  logic          vd;
  logic [NW-1:0] nmag [3];
  logic [NW-1:0] dmag_d;
  logic [2:0]    neg_d;
  logic          dz_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else begin
      vd <= vc;
    end
    for (int i = 0; i < 3; i++) begin
      nmag[i]  <= num[i][NW-1] ? NW'(-num[i]) : NW'(num[i]);
      neg_d[i] <= (num[i] != '0) && (num[i][NW-1] == den[NW-1]);
    end
    dmag_d <= den[NW-1] ? NW'(-den) : NW'(den);
    dz_d   <= (den == '0);
  end

  // Division pipeline arrays; index 0 is the setup stage.
  logic          dv   [0:QB];
  logic [WW-1:0] rem  [0:QB][3];
  logic [QB-1:0] quo  [1:QB][3];
  logic [NW-1:0] dmag [0:QB];
  logic [2:0]    negs [0:QB];
  logic [2:0]    ovfs [0:QB];
  logic          dzs  [0:QB];

  // Stage E: scaled dividends and the quotient overflow check.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= vd;
    end
    for (int i = 0; i < 3; i++) begin
      rem[0][i]  <= WW'(nmag[i]) << WEIGHT_FRAC_BITS;
      ovfs[0][i] <= WW'(nmag[i]) >= (WW'(dmag_d) << (QB - WEIGHT_FRAC_BITS));
    end
    dmag[0] <= dmag_d;
    negs[0] <= neg_d;
    dzs[0]  <= dz_d;
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = QB - 1 - j;
    logic [WW-1:0] trial;
    logic [2:0]    qbit;
    logic [WW-1:0] rdiff [3];

    assign trial = WW'(dmag[j]) << K;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        qbit[i]  = rem[j][i] >= trial;
        rdiff[i] = rem[j][i] - trial;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else begin
        dv[j+1] <= dv[j];
      end
      for (int i = 0; i < 3; i++) begin
        rem[j+1][i] <= qbit[i] ? rdiff[i] : rem[j][i];
      end
      dmag[j+1] <= dmag[j];
      negs[j+1] <= negs[j];
      ovfs[j+1] <= ovfs[j];
      dzs[j+1]  <= dzs[j];
    end

    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        for (int i = 0; i < 3; i++) begin
          quo[1][i] <= QB'(qbit[i]);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        for (int i = 0; i < 3; i++) begin
          quo[j+1][i] <= {quo[j][i][QB-2:0], qbit[i]};
        end
      end
    end
  end

  // Output stage: sign, saturation and the zero-area override.
  weight_t w_next [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dzs[QB]) begin
        w_next[i] = '0;
      end else if (negs[QB][i]) begin
        w_next[i] = (ovfs[QB][i] || quo[QB][i][QB-1]) ? {1'b1, {(QB-1){1'b0}}}
                                                        : weight_t'(-quo[QB][i]);
      end else begin
        w_next[i] = (ovfs[QB][i] || quo[QB][i][QB-1]) ? {1'b0, {(QB-1){1'b1}}}
                                                        : weight_t'(quo[QB][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[QB];
    end
    weight_one   <= w_next[0];
    weight_two   <= w_next[1];
    weight_three <= w_next[2];
    degenerate   <= dzs[QB];
  end

endmodule
`default_nettype wire

[rtl/core/bw2d_checker.sv]
// Port-level checks of the barycentric weight pipeline and their binding.
`timescale 1ns / 1ps
`default_nettype none
module bw2d_checker
  import bw2d_pkg::*;
(
  input wire          clk,
  input wire          rst,
  input wire          start,
  input wire          busy,
  input wire          done,
  input wire weight_t weight_one,
  input wire weight_t weight_two,
  input wire weight_t weight_three,
  input wire          degenerate
);

  // The pipeline takes a word in every cycle outside reset.
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised outside reset");

  // Every accepted word gives a result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LATENCY done)
    else $error("result missing after pipeline latency");

  // A zero-area result carries zero weights.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (weight_one == '0 && weight_two == '0 &&
                              weight_three == '0))
    else $error("degenerate result with nonzero weights");

  // No result comes out of the pipeline right after reset is released.
  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> !done)
    else $error("result strobe right after reset");

endmodule

bind barycentric_weights_2d bw2d_checker u_bw2d_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .weight_one   (weight_one),
  .weight_two   (weight_two),
  .weight_three (weight_three),
  .degenerate   (degenerate)
);
`default_nettype wire

[tb/barycentric_weights_2d_tb.sv]
// Self-checking testbench of the 2D barycentric weight pipeline.
`timescale 1ns / 1ps
module barycentric_weights_2d_tb;
  import bw2d_pkg::*;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_RANDOM = 1930;
  localparam int IDLE_LIMIT = 4 * PIPE_LATENCY + 200;

  // One input word: point, then vertices one to three, as x/y pairs.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] px, py, x1, y1, x2, y2, x3, y3;
  } tri_word_t;

  // One result word.
  typedef struct packed {
    weight_t w1, w2, w3;
    logic    degen;
  } weights_t;

  // Directed row: the word, and a typed-in result where one is obvious.
  typedef struct packed {
    tri_word_t word;
    logic      known;
    weights_t  res;
  } dir_row_t;

  localparam logic signed [15:0] MAXC = 16'sh7fff;
  localparam logic signed [15:0] MINC = 16'sh8000;
  localparam weight_t WMAX = 32'sh7fffffff;
  localparam weight_t WMIN = 32'sh80000000;
  localparam weight_t ONE  = 32'sh00010000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, degenerate;
  logic signed [COORD_BITS-1:0] point_x = '0, point_y = '0;
  logic signed [COORD_BITS-1:0] vertex1_x = '0, vertex1_y = '0;
  logic signed [COORD_BITS-1:0] vertex2_x = '0, vertex2_y = '0;
  logic signed [COORD_BITS-1:0] vertex3_x = '0, vertex3_y = '0;
  weight_t weight_one, weight_two, weight_three;

  weights_t pending_weights[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int degen_seen = 0;
  int sat_seen = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  barycentric_weights_2d #(
    .COORD_BITS(COORD_BITS),
    .WEIGHT_FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y),
    .vertex1_x(vertex1_x), .vertex1_y(vertex1_y),
    .vertex2_x(vertex2_x), .vertex2_y(vertex2_y),
    .vertex3_x(vertex3_x), .vertex3_y(vertex3_y),
    .done(done), .weight_one(weight_one), .weight_two(weight_two),
    .weight_three(weight_three), .degenerate(degenerate)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One weight: -(num * 2^FRAC_BITS) / den, truncated toward zero, saturated.
  function automatic weight_t quotient_weight(longint num, longint den);
    logic signed [127:0] q;
    q = -((128'(signed'(num))) <<< FRAC_BITS) / 128'(signed'(den));
    if (q > 128'sd2147483647) return WMAX;
    if (q < -128'sd2147483648) return WMIN;
    return weight_t'(q[31:0]);
  endfunction

  // Barycentric weights from the cross-product numerators and doubled area.
  function automatic weights_t tri_weights(tri_word_t t);
    longint px, py, x1, y1, x2, y2, x3, y3, n1, n2, n3, d;
    weights_t r;
    px = t.px; py = t.py; x1 = t.x1; y1 = t.y1;
    x2 = t.x2; y2 = t.y2; x3 = t.x3; y3 = t.y3;
    n1 = -x2*py + x3*py + px*y2 - x3*y2 - px*y3 + x2*y3;
    n2 = x1*py - x3*py - px*y1 + x3*y1 + px*y3 - x1*y3;
    n3 = -x1*py + x2*py + px*y1 - x2*y1 - px*y2 + x1*y2;
    d  = x2*y1 - x3*y1 - x1*y2 + x3*y2 + x1*y3 - x2*y3;
    if (d == 0) begin
      r = '{w1: '0, w2: '0, w3: '0, degen: 1'b1};
    end else begin
      r.w1 = quotient_weight(n1, d);
      r.w2 = quotient_weight(n2, d);
      r.w3 = quotient_weight(n3, d);
      r.degen = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("MISMATCH word %0d %s: got %0d expected %0d", words_checked, what, got, want);
  endtask

  // Drive one word and hold it until it is taken; start stays high between words.
  task automatic send_word(tri_word_t t, weights_t want);
    {point_x, point_y, vertex1_x, vertex1_y,
     vertex2_x, vertex2_y, vertex3_x, vertex3_y} <= t;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_weights.push_back(want);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_coord(int mode);
    case (mode)
      0: return $urandom_range(0, 3) == 0 ? MAXC : MINC;
      1: return 16'($signed($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  // Random triangle: mostly proper ones, some thin or collapsed ones.
  function automatic tri_word_t rand_tri();
    tri_word_t t;
    int kind, m;
    kind = $urandom_range(0, 9);
    m = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 3) == 0 ? 1 : 2);
    t.px = rand_coord(m); t.py = rand_coord(m);
    t.x1 = rand_coord(m); t.y1 = rand_coord(m);
    t.x2 = rand_coord(m); t.y2 = rand_coord(m);
    t.x3 = rand_coord(m); t.y3 = rand_coord(m);
    if (kind == 0) begin
      // Two vertices coincide.
      t.x3 = t.x1; t.y3 = t.y1;
    end else if (kind == 1) begin
      // Collinear vertices on an axis-aligned line.
      t.y2 = t.y1; t.y3 = t.y1;
    end else if (kind == 2) begin
      // Tiny triangle with a far point drives the weights into saturation.
      t.x2 = t.x1 + 16'sd1; t.y2 = t.y1;
      t.x3 = t.x1; t.y3 = t.y1 + 16'sd1;
    end
    return t;
  endfunction

  // Stimulus: directed table first, then random bursts.
  initial begin
    dir_row_t rows[$];
    dir_row_t r;
    weights_t want;
    int burst;
    rows.push_back('{'{'0, '0, '0, '0, '0, '0, '0, '0}, 1'b1, '{'0, '0, '0, 1'b1}});
    rows.push_back('{'{'0, '0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1}, 1'b0, '0});
    rows.push_back('{'{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1},
                     1'b0, '0});
    rows.push_back('{'{MAXC, MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC}, 1'b0, '0});
    rows.push_back('{'{MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC}, 1'b0, '0});
    rows.push_back('{'{MAXC, MINC, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1},
                     1'b0, '0});
    rows.push_back('{'{MINC, MAXC, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1},
                     1'b0, '0});
    rows.push_back('{'{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC}, 1'b1,
                     '{'0, '0, '0, 1'b1}});
    rows.push_back('{'{MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC}, 1'b1,
                     '{'0, '0, '0, 1'b1}});
    rows.push_back('{'{16'sd5, 16'sd5, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd2, 16'sd2},
                     1'b1, '{'0, '0, '0, 1'b1}});
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1},
                     1'b0, '0});
    rows.push_back('{'{16'sd3, 16'sd3, MINC, MINC, MAXC, MINC, MINC, MAXC}, 1'b0, '0});
    rows.push_back('{'{-16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0},
                     1'b0, '0});
    rows.push_back('{'{16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555, 16'sh5555, 16'sh5555,
                       16'shaaaa, 16'shaaaa}, 1'b0, '0});
    rows.push_back('{'{16'shaaaa, 16'sh5555, 16'sh5555, 16'shaaaa, 16'shaaaa, 16'shaaaa,
                       16'sh5555, 16'sh5555}, 1'b0, '0});

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      r = rows[i];
      want = r.known ? r.res : tri_weights(r.word);
      send_word(r.word, want);
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 3));
    end
    // Hold off until everything so far has come out.
    start <= 1'b0;
    while (pending_weights.size() != 0) @(negedge clk);

    for (int n = 0; n < NUM_RANDOM; ) begin
      burst = $urandom_range(1, 60);
      for (int b = 0; b < burst && n < NUM_RANDOM; b++, n++) begin
        tri_word_t t;
        t = rand_tri();
        send_word(t, tri_weights(t));
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 45));
    end
    start <= 1'b0;
    stim_done = 1'b1;
  end

  // Result checking at the rising edge.
  always @(posedge clk) begin
    weights_t want;
    if (!rst && done) begin
      if (pending_weights.size() == 0) begin
        report_mismatch("unexpected result word", 1, 0);
      end else begin
        want = pending_weights.pop_front();
        if (weight_one !== want.w1) report_mismatch("weight_one", weight_one, want.w1);
        if (weight_two !== want.w2) report_mismatch("weight_two", weight_two, want.w2);
        if (weight_three !== want.w3)
          report_mismatch("weight_three", weight_three, want.w3);
        if (degenerate !== want.degen)
          report_mismatch("degenerate", degenerate, want.degen);
        if (want.degen) degen_seen++;
        if (!want.degen && (want.w1 == WMAX || want.w1 == WMIN)) sat_seen++;
        words_checked++;
      end
    end
  end

  // Watchdog on cycles with nothing accepted and no result coming out.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Timeout with %0d result words outstanding", pending_weights.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (pending_weights.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    $display("Ran %0d triangle words, %0d results checked.", words_sent, words_checked);
    $display("Zero-area triangles: %0d, saturated first weights: %0d.", degen_seen, sat_seen);
    if (errors == 0 && pending_weights.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/bw2d_pkg.sv
rtl/core/barycentric_weights_2d.sv
rtl/core/bw2d_checker.sv
tb/barycentric_weights_2d_tb.sv
